// ===== rtl/pce_pkg.sv =====
`default_nettype none

package pce_pkg;

    // Sizing of the device table and the bridge frame stack.
    localparam int MAX_DEVICES = 32;
    localparam int STACK_DEPTH = 16;
    localparam int RC_W        = $clog2(MAX_DEVICES + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);

    // Result buffer between the walker and the result channel.
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    // Finish status codes.
    localparam logic [1:0] FIN_OK         = 2'd0;
    localparam logic [1:0] FIN_TABLE_FULL = 2'd1;
    localparam logic [1:0] FIN_STACK_OVF  = 2'd2;

    // Configuration space offsets and field values.
    localparam logic [7:0]  OFF_VENDOR     = 8'h00;
    localparam logic [7:0]  OFF_CLASS      = 8'h08;
    localparam logic [7:0]  OFF_HDR        = 8'h0c;
    localparam logic [7:0]  OFF_BUSNUM     = 8'h18;
    localparam logic [7:0]  OFF_MASK       = 8'hfc;
    localparam logic [15:0] VENDOR_ABSENT  = 16'hffff;
    localparam logic [7:0]  CLASS_BRIDGE   = 8'h06;
    localparam logic [7:0]  SUB_PCI_BRIDGE = 8'h04;
    localparam int          HDR_MF_BIT     = 7;
    localparam logic [4:0]  LAST_DEV       = 5'd31;
    localparam logic [2:0]  LAST_FN        = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [31:0] read_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] config_address;
        logic [7:0]  bus;
        logic [4:0]  device;
        logic [2:0]  function_res;
        logic [7:0]  hdr_type;
        logic [7:0]  base_class;
        logic [7:0]  sub_class;
        logic [7:0]  prog_interface;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0] bus;
        logic [4:0] dev;
        logic [2:0] fn;
    } pos_t;

    // A root frame holds the host function in pos.fn.
    typedef struct packed {
        logic root;
        pos_t pos;
    } frame_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HOST_HDR,
        PH_HOST_VENDOR,
        PH_BUS_VENDOR,
        PH_FN_CLASS,
        PH_FN_HDR,
        PH_FN_BUSNUM,
        PH_DEV_HDR,
        PH_FN_VENDOR
    } phase_t;

    typedef enum logic [1:0] {
        ENG_RUN,
        ENG_FOLLOW,
        ENG_POP
    } eng_state_t;

    // Outcome of advancing past a finished function or device.
    typedef struct packed {
        logic       pop;
        pos_t       pos;
        logic [7:0] off;
        phase_t     phase;
    } step_t;

    typedef struct packed {
        logic         wr_en;
        logic [SA_W-1:0] wr_addr;
        frame_t       wr_data;
        logic         rd_en;
        logic [SA_W-1:0] rd_addr;
    } stack_req_t;

    function automatic result_t make_request(pos_t p, logic [7:0] off);
        result_t r;
        r = '0;
        r.kind           = KIND_REQUEST;
        r.config_address = {1'b1, 7'b0, p.bus, p.dev, p.fn, off & OFF_MASK};
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic result_t make_finish(logic [1:0] st);
        result_t r;
        r = '0;
        r.kind   = KIND_FINISH;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic step_t dev_done(pos_t p);
        step_t s;
        s = '0;
        s.pos = p;
        if (p.dev != LAST_DEV) begin
            s.pos.dev = p.dev + 5'd1;
            s.pos.fn  = '0;
            s.off     = OFF_VENDOR;
            s.phase   = PH_BUS_VENDOR;
        end
        else begin
            s.pop = 1'b1;
        end
        return s;
    endfunction

    function automatic step_t fn_done(pos_t p);
        step_t s;
        s = '0;
        s.pos = p;
        if (p.fn == 3'd0) begin
            s.off   = OFF_HDR;
            s.phase = PH_DEV_HDR;
        end
        else if (p.fn != LAST_FN) begin
            s.pos.fn = p.fn + 3'd1;
            s.off    = OFF_VENDOR;
            s.phase  = PH_FN_VENDOR;
        end
        else begin
            s = dev_done(p);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pce_frame_stack.sv =====
`default_nettype none

module pce_frame_stack (
    input  wire                 clk,
    input  pce_pkg::stack_req_t req,
    output pce_pkg::frame_t     rd_data
);
    import pce_pkg::*;

    frame_t mem [STACK_DEPTH];
    frame_t rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pce_result_fifo.sv =====
`default_nettype none

module pce_result_fifo (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  pce_pkg::result_t push_data,
    output logic             full,
    output logic             result_valid,
    input  wire              result_stall,
    output pce_pkg::result_t result
);
    import pce_pkg::*;

    result_t              slots [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign result_valid = (count_reg != '0);
    assign full         = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign pop          = result_valid && !result_stall;
    assign result       = slots[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pce_walker.sv =====
`default_nettype none

module pce_walker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_stall,
    input  pce_pkg::item_t      item,
    input  wire                 fifo_full,
    output logic                push,
    output pce_pkg::result_t    push_data,
    output pce_pkg::stack_req_t stack_req,
    input  pce_pkg::frame_t     stack_rd_data
);
    import pce_pkg::*;

    eng_state_t       state_reg, state_next;
    phase_t           phase_reg, phase_next;
    pos_t             pos_reg, pos_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [RC_W-1:0]  rc_reg, rc_next;
    logic [23:0]      class_reg, class_next;

    logic             accept;
    logic             act_follow;
    logic             act_pop;
    logic             use_walk;
    step_t            wk;
    logic [15:0]      vendor;
    logic [7:0]       hdr;
    frame_t           frame;
    pos_t             root_pos;

    assign item_stall = (state_reg != ENG_RUN) || fifo_full;
    assign accept     = item_valid && !item_stall;
    assign vendor     = item.read_data[15:0];
    assign hdr        = item.read_data[23:16];
    assign frame      = stack_rd_data;

    // Step decode: results, stack traffic and the next scan position.
    always_comb
    begin
        push        = 1'b0;
        push_data   = '0;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        sp_next     = sp_reg;
        rc_next     = rc_reg;
        class_next  = class_reg;
        stack_req   = '0;
        act_follow  = 1'b0;
        act_pop     = 1'b0;
        use_walk    = 1'b0;
        wk          = '0;
        root_pos    = '0;

        case (state_reg)
            ENG_RUN:
            begin
                if (accept && item.opcode == OP_START)
                begin
                    rc_next    = '0;
                    sp_next    = '0;
                    class_next = '0;
                    pos_next   = '0;
                    push       = 1'b1;
                    push_data  = make_request('0, OFF_HDR);
                    phase_next = PH_HOST_HDR;
                end
                else if (accept)
                begin
                    case (phase_reg)
                        PH_HOST_HDR, PH_HOST_VENDOR:
                        begin
                            push = 1'b1;
                            if ((phase_reg == PH_HOST_HDR && !hdr[HDR_MF_BIT]) ||
                                (phase_reg == PH_HOST_VENDOR && vendor != VENDOR_ABSENT))
                            begin
                                // Open the root bus and push its frame.
                                root_pos.fn = (phase_reg == PH_HOST_HDR) ? 3'd0 : pos_reg.fn;
                                stack_req.wr_en   = 1'b1;
                                stack_req.wr_addr = '0;
                                stack_req.wr_data = {1'b1, root_pos};
                                sp_next           = SP_W'(1);
                                pos_next          = '0;
                                pos_next.bus      = {5'b0, root_pos.fn};
                                push_data  = make_request(pos_next, OFF_VENDOR);
                                phase_next = PH_BUS_VENDOR;
                            end
                            else if (phase_reg == PH_HOST_VENDOR && pos_reg.fn == LAST_FN)
                            begin
                                push_data  = make_finish(FIN_OK);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                pos_next    = '0;
                                pos_next.fn = (phase_reg == PH_HOST_HDR) ?
                                              3'd1 : pos_reg.fn + 3'd1;
                                push_data   = make_request(pos_next, OFF_VENDOR);
                                phase_next  = PH_HOST_VENDOR;
                            end
                        end
                        PH_BUS_VENDOR, PH_FN_VENDOR:
                        begin
                            if (vendor == VENDOR_ABSENT)
                            begin
                                use_walk = 1'b1;
                                wk = (phase_reg == PH_BUS_VENDOR) ? dev_done(pos_reg)
                                                                  : fn_done(pos_reg);
                            end
                            else
                            begin
                                push       = 1'b1;
                                push_data  = make_request(pos_reg, OFF_CLASS);
                                phase_next = PH_FN_CLASS;
                            end
                        end
                        PH_FN_CLASS:
                        begin
                            class_next = item.read_data[31:8];
                            push       = 1'b1;
                            push_data  = make_request(pos_reg, OFF_HDR);
                            phase_next = PH_FN_HDR;
                        end
                        PH_FN_HDR:
                        begin
                            push = 1'b1;
                            if (rc_reg >= RC_W'(MAX_DEVICES))
                            begin
                                push_data  = make_finish(FIN_TABLE_FULL);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                // Device record; ENG_FOLLOW sends the follow-up.
                                push_data.kind           = KIND_RECORD;
                                push_data.bus            = pos_reg.bus;
                                push_data.device         = pos_reg.dev;
                                push_data.function_res   = pos_reg.fn;
                                push_data.hdr_type       = hdr;
                                push_data.base_class     = class_reg[23:16];
                                push_data.sub_class      = class_reg[15:8];
                                push_data.prog_interface = class_reg[7:0];
                                rc_next    = rc_reg + RC_W'(1);
                                act_follow = 1'b1;
                            end
                        end
                        PH_FN_BUSNUM:
                        begin
                            push = 1'b1;
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                            begin
                                push_data  = make_finish(FIN_STACK_OVF);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                stack_req.wr_en   = 1'b1;
                                stack_req.wr_addr = sp_reg[SA_W-1:0];
                                stack_req.wr_data = {1'b0, pos_reg};
                                sp_next           = sp_reg + SP_W'(1);
                                pos_next          = '0;
                                pos_next.bus      = item.read_data[15:8];
                                push_data  = make_request(pos_next, OFF_VENDOR);
                                phase_next = PH_BUS_VENDOR;
                            end
                        end
                        PH_DEV_HDR:
                        begin
                            if (!hdr[HDR_MF_BIT])
                            begin
                                use_walk = 1'b1;
                                wk       = dev_done(pos_reg);
                            end
                            else
                            begin
                                pos_next.fn = 3'd1;
                                push        = 1'b1;
                                push_data   = make_request(pos_next, OFF_VENDOR);
                                phase_next  = PH_FN_VENDOR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ENG_FOLLOW:
            begin
                if (!fifo_full)
                begin
                    if (class_reg[23:16] == CLASS_BRIDGE && class_reg[15:8] == SUB_PCI_BRIDGE)
                    begin
                        push       = 1'b1;
                        push_data  = make_request(pos_reg, OFF_BUSNUM);
                        phase_next = PH_FN_BUSNUM;
                    end
                    else
                    begin
                        use_walk = 1'b1;
                        wk       = fn_done(pos_reg);
                    end
                end
            end
            ENG_POP:
            begin
                if (!fifo_full)
                begin
                    if (frame.root)
                    begin
                        push = 1'b1;
                        if (frame.pos.fn == 3'd0 || frame.pos.fn == LAST_FN)
                        begin
                            push_data  = make_finish(FIN_OK);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            pos_next    = '0;
                            pos_next.fn = frame.pos.fn + 3'd1;
                            push_data   = make_request(pos_next, OFF_VENDOR);
                            phase_next  = PH_HOST_VENDOR;
                        end
                    end
                    else
                    begin
                        use_walk = 1'b1;
                        wk       = fn_done(frame.pos);
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Advance to the next device or function, or pop a bus frame.
        if (use_walk)
        begin
            pos_next = wk.pos;
            if (!wk.pop)
            begin
                push       = 1'b1;
                push_data  = make_request(wk.pos, wk.off);
                phase_next = wk.phase;
            end
            else if (sp_reg == '0)
            begin
                push       = 1'b1;
                push_data  = make_finish(FIN_OK);
                phase_next = PH_IDLE;
            end
            else
            begin
                sp_next           = sp_reg - SP_W'(1);
                stack_req.rd_en   = 1'b1;
                stack_req.rd_addr = sp_next[SA_W-1:0];
                act_pop           = 1'b1;
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_RUN:
            begin
                if (act_follow)
                begin
                    state_next = ENG_FOLLOW;
                end
                else if (act_pop)
                begin
                    state_next = ENG_POP;
                end
            end
            ENG_FOLLOW, ENG_POP:
            begin
                if (act_pop)
                begin
                    state_next = ENG_POP;
                end
                else if (!fifo_full)
                begin
                    state_next = ENG_RUN;
                end
            end
            default:
            begin
                state_next = ENG_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_RUN;
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            sp_reg    <= '0;
            rc_reg    <= '0;
            class_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sp_reg    <= sp_next;
            rc_reg    <= rc_next;
            class_reg <= class_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pci_config_enumerator.sv =====
`default_nettype none

// Channel   Direction  Payload          Handshake
// item      in         pce_pkg::item_t    item_valid / item_stall
// result    out        pce_pkg::result_t  result_valid / result_stall
//
// An item that reports a device yields its record and the follow-up request or finish
// in separate steps, the record first. Each bridge frame taken off the stack adds a
// step for the stack memory read.
// Reset clears the sequencer, counters and result buffer; the stack memory is not cleared.
// item_stall is high while the walker finishes a step or the four-entry result buffer is full.

module pci_config_enumerator (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_stall,
    input  pce_pkg::item_t   item,
    output logic             result_valid,
    input  wire              result_stall,
    output pce_pkg::result_t result
);
    import pce_pkg::*;

    logic       fifo_full;
    logic       push;
    result_t    push_data;
    stack_req_t stack_req;
    frame_t     stack_rd_data;

    pce_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_data    (push_data),
        .stack_req    (stack_req),
        .stack_rd_data(stack_rd_data)
    );

    pce_frame_stack u_stack (
        .clk    (clk),
        .req    (stack_req),
        .rd_data(stack_rd_data)
    );

    pce_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (push_data),
        .full        (fifo_full),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== rtl/pce_checker.sv =====
`default_nettype none

module pce_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              item_valid,
    input wire              item_stall,
    input pce_pkg::item_t   item,
    input wire              result_valid,
    input wire              result_stall,
    input pce_pkg::result_t result
);
    import pce_pkg::*;

    // A device record is never marked as the last result; a request or a finish follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_RECORD |-> !result.last)
        else $error("device record marked as last result");

    // Only requests carry an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_REQUEST |-> result.config_address == 32'd0)
        else $error("address on a non-request result");

    // Every request has the configuration enable bit set.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_REQUEST |-> result.config_address[31])
        else $error("request without enable bit");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A stalled input transaction holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled item changed");

endmodule

bind pci_config_enumerator pce_checker u_pce_checker (.*);

`default_nettype wire
